### rtl/packet_header_parser_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the header parser modules.
// Each macro expects clk and rst in scope; checks are off during reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_HEADER_PARSER_TOP_MACROS_SVH
`define PACKET_HEADER_PARSER_TOP_MACROS_SVH

// Check that cond holds in the same cycle as ante.
`define PHDR_ASSERT_SAME(label, ante, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after ante.
`define PHDR_ASSERT_NEXT(label, ante, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cond)) \
    else $error(msg);

`endif

### rtl/phdr_pkg.sv
// ---------------------------------------------------------------------------
// phdr_pkg
// Types, codes and helpers for the packet header parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package phdr_pkg;

  // Width of the indeterminate-length byte counter
  localparam int COUNT_BITS = 32;
  localparam int BODY_W     = 32;

  // Parser phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_NEW1  = 3'd1;
  localparam logic [2:0] PH_NEW2  = 3'd2;
  localparam logic [2:0] PH_NEW5  = 3'd3;
  localparam logic [2:0] PH_LEG   = 3'd4;
  localparam logic [2:0] PH_COUNT = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_NEW = 2'd1;
  localparam logic [1:0] ST_BAD_LEG = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Legacy length-type codes
  localparam logic [1:0] LT_ONE   = 2'd0;
  localparam logic [1:0] LT_TWO   = 2'd1;
  localparam logic [1:0] LT_FOUR  = 2'd2;
  localparam logic [1:0] LT_INDET = 2'd3;

  // New-format first length octet thresholds
  localparam logic [7:0] NEW_FIVE_MARK   = 8'd255;
  localparam logic [7:0] NEW_PARTIAL_MIN = 8'd224;
  localparam logic [7:0] NEW_TWO_MIN     = 8'd192;

  // Header sizes in octets
  localparam logic [2:0] HDR_TAG_ONLY = 3'd1;
  localparam logic [2:0] HDR_ONE_LEN  = 3'd2;
  localparam logic [2:0] HDR_TWO_LEN  = 3'd3;
  localparam logic [2:0] HDR_FOUR_LEN = 3'd5;
  localparam logic [2:0] HDR_FIVE_LEN = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        tag_byte;
    logic [5:0]        pkt_type;
    logic              new_format;
    logic [2:0]        header_octets;
    logic [BODY_W-1:0] body_length;
    logic              partial_start;
    logic              indeterminate;
  } hdr_info_t;

  // Packet type field from a tag octet
  function automatic logic [5:0] type_of(input logic [7:0] tag);
    logic [5:0] t;
    if (tag[7] && tag[6]) begin
      t = tag[5:0];
    end else begin
      t = {2'b00, tag[5:2]};
    end
    return t;
  endfunction

  // Count of length octets for a legacy length type
  function automatic logic [2:0] leg_len_octets(input logic [1:0] lt);
    logic [2:0] n;
    case (lt)
      LT_ONE:  n = 3'd1;
      LT_TWO:  n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // Header size for a legacy length type
  function automatic logic [2:0] leg_hdr_octets(input logic [1:0] lt);
    logic [2:0] n;
    case (lt)
      LT_ONE:  n = HDR_ONE_LEN;
      LT_TWO:  n = HDR_TWO_LEN;
      default: n = HDR_FOUR_LEN;
    endcase
    return n;
  endfunction

endpackage

### rtl/phdr_in_stage.sv
// ---------------------------------------------------------------------------
// phdr_in_stage
// Input register: holds one byte transfer until the parser consumes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phdr_in_stage import phdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  input  logic       advance,
  output logic       held,
  output byte_item_t item
);

  // Take a new byte when empty or when the held byte moves on this cycle
  assign byte_ready = !held || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_ready) begin
      held <= byte_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      item <= byte_item;
    end
  end

endmodule

### rtl/phdr_parse.sv
// ---------------------------------------------------------------------------
// phdr_parse
// Header state machine: walks the tag and length octets of one buffer
// and forms the header result on the byte that completes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_header_parser_top_macros.svh"

module phdr_parse import phdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  byte_item_t item,
  output logic       res_valid,
  output hdr_info_t  res
);

  logic [2:0]            phase;
  logic [2:0]            phase_next;
  logic [7:0]            saved_tag;
  logic [7:0]            saved_tag_next;
  logic [BODY_W-1:0]     length_accum;
  logic [BODY_W-1:0]     length_accum_next;
  logic [2:0]            bytes_left;
  logic [2:0]            bytes_left_next;
  logic [COUNT_BITS-1:0] buffer_count;
  logic [COUNT_BITS-1:0] buffer_count_next;

  logic              emit;
  logic [1:0]        st;
  logic [2:0]        hdr;
  logic [BODY_W-1:0] body;
  logic              part;
  logic              indet;
  logic [7:0]        tag_now;
  logic [7:0]        b;
  logic              last;
  logic [2:0]        after;
  logic [2:0]        left_dec;
  logic [BODY_W-1:0] accum_shift;

  assign b           = item.data_byte;
  assign last        = item.last_byte;
  assign after       = last ? PH_IDLE : PH_SKIP;
  assign left_dec    = bytes_left - 3'd1;
  assign accum_shift = {length_accum[BODY_W-9:0], b};
  assign tag_now     = (phase == PH_IDLE) ? b : saved_tag;

  // Decode one byte against the current phase
  always_comb begin
    phase_next        = phase;
    saved_tag_next    = saved_tag;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    buffer_count_next = buffer_count;
    emit  = 1'b0;
    st    = ST_OK;
    hdr   = 3'd0;
    body  = '0;
    part  = 1'b0;
    indet = 1'b0;
    unique case (phase) inside
      PH_IDLE: begin
        saved_tag_next    = b;
        length_accum_next = '0;
        bytes_left_next   = 3'd0;
        buffer_count_next = COUNT_BITS'(1);
        if (!b[7]) begin
          emit       = 1'b1;
          st         = ST_UNKNOWN;
          phase_next = after;
        end else if (b[6]) begin
          if (last) begin
            emit       = 1'b1;
            st         = ST_BAD_NEW;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_NEW1;
          end
        end else if (b[1:0] == LT_INDET) begin
          if (last) begin
            emit       = 1'b1;
            hdr        = HDR_TAG_ONLY;
            indet      = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_COUNT;
          end
        end else if (last) begin
          emit       = 1'b1;
          st         = ST_BAD_LEG;
          phase_next = PH_IDLE;
        end else begin
          bytes_left_next = leg_len_octets(b[1:0]);
          phase_next      = PH_LEG;
        end
      end
      PH_NEW1: begin
        if (b == NEW_FIVE_MARK) begin
          if (last) begin
            emit       = 1'b1;
            st         = ST_BAD_NEW;
            phase_next = PH_IDLE;
          end else begin
            length_accum_next = '0;
            bytes_left_next   = 3'd4;
            phase_next        = PH_NEW5;
          end
        end else if (b >= NEW_PARTIAL_MIN) begin
          emit       = 1'b1;
          hdr        = HDR_ONE_LEN;
          body       = BODY_W'(1) << b[4:0];
          part       = 1'b1;
          phase_next = after;
        end else if (b >= NEW_TWO_MIN) begin
          if (last) begin
            emit       = 1'b1;
            st         = ST_BAD_NEW;
            phase_next = PH_IDLE;
          end else begin
            length_accum_next = BODY_W'(b);
            phase_next        = PH_NEW2;
          end
        end else begin
          emit       = 1'b1;
          hdr        = HDR_ONE_LEN;
          body       = BODY_W'(b);
          phase_next = after;
        end
      end
      PH_NEW2: begin
        emit       = 1'b1;
        hdr        = HDR_TWO_LEN;
        body       = ((BODY_W'(length_accum[7:0]) - BODY_W'(NEW_TWO_MIN)) << 8)
                     + BODY_W'(b) + BODY_W'(NEW_TWO_MIN);
        phase_next = after;
      end
      PH_NEW5, PH_LEG: begin
        length_accum_next = accum_shift;
        bytes_left_next   = left_dec;
        if (left_dec == 3'd0) begin
          emit       = 1'b1;
          hdr        = (phase == PH_NEW5) ? HDR_FIVE_LEN : leg_hdr_octets(saved_tag[1:0]);
          body       = accum_shift;
          phase_next = after;
        end else if (last) begin
          emit       = 1'b1;
          st         = (phase == PH_NEW5) ? ST_BAD_NEW : ST_BAD_LEG;
          phase_next = PH_IDLE;
        end
      end
      PH_COUNT: begin
        buffer_count_next = buffer_count + COUNT_BITS'(1);
        if (last) begin
          // count minus one before the bump equals the old count
          emit       = 1'b1;
          hdr        = HDR_TAG_ONLY;
          body       = BODY_W'(buffer_count);
          indet      = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_SKIP: begin
        if (last) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Advance control state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      saved_tag    <= '0;
      length_accum <= '0;
      bytes_left   <= '0;
      buffer_count <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      saved_tag    <= saved_tag_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      buffer_count <= buffer_count_next;
    end
  end

  // Form the result fields
  assign res_valid         = fire && emit;
  assign res.status        = st;
  assign res.tag_byte      = tag_now;
  assign res.pkt_type      = tag_now[7] ? type_of(tag_now) : 6'd0;
  assign res.new_format    = tag_now[7] && tag_now[6];
  assign res.header_octets = hdr;
  assign res.body_length   = body;
  assign res.partial_start = part;
  assign res.indeterminate = indet;

  `PHDR_ASSERT_SAME(a_ok_has_header, res_valid && res.status == ST_OK,
    res.header_octets != 3'd0, "good header reported with zero size")
  `PHDR_ASSERT_SAME(a_err_no_body, res_valid && res.status != ST_OK,
    res.body_length == '0 && res.header_octets == 3'd0, "error carries length")
  `PHDR_ASSERT_SAME(a_skip_silent, fire && phase == PH_SKIP,
    !res_valid, "result produced while skipping body bytes")
  `PHDR_ASSERT_NEXT(a_last_to_idle, fire && item.last_byte,
    phase == PH_IDLE, "parser not idle after last byte")

endmodule

### rtl/phdr_out_reg.sv
// ---------------------------------------------------------------------------
// phdr_out_reg
// Result register: holds one header result until the consumer takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phdr_out_reg import phdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  logic      res_valid,
  input  hdr_info_t res,
  output logic      free,
  output logic      hdr_valid,
  input  logic      hdr_ready,
  output hdr_info_t hdr_info
);

  // Room for a new result when empty or being drained
  assign free = !hdr_valid || hdr_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (fire) begin
      hdr_valid <= res_valid;
    end else if (hdr_ready) begin
      hdr_valid <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      hdr_info <= res;
    end
  end

endmodule

### rtl/packet_header_parser_top.sv
// ---------------------------------------------------------------------------
// packet_header_parser_top
// Parses the packet header at the start of each byte buffer and reports
// tag, type, format, header size, body length and status.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// byte      in         byte_valid / byte_ready   byte_item (data_byte, last_byte)
// hdr       out        hdr_valid  / hdr_ready    hdr_info (one result per header)
//
// One byte per cycle sustained while hdr_ready holds high; a byte passes the
// input register, then is decoded into the result register.
// The decode state machine advances once per byte, so it sets the rate.
// Reset (rst, synchronous) returns the parser to waiting for a tag.
// A stall on hdr_ready holds the input register; bytes keep flowing
// until both registers are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_parser_top import phdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       hdr_valid,
  input  logic       hdr_ready,
  output hdr_info_t  hdr_info
);

  logic       free;
  logic       held;
  logic       fire;
  byte_item_t item;
  logic       res_valid;
  hdr_info_t  res;

  // Consume the held byte whenever the result register has room
  assign fire = held && free;

  phdr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .advance    (free),
    .held       (held),
    .item       (item)
  );

  phdr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  phdr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .free      (free),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_info  (hdr_info)
  );

endmodule

### test/phdr_result_checker.sv
// ---------------------------------------------------------------------------
// phdr_result_checker
// Watches the byte and header channels of the packet header parser. It
// predicts the header result from each accepted byte and compares every
// accepted result, field by field, with the oldest pending prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phdr_result_checker import phdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  byte_item_t byte_item,
  input  logic       hdr_valid,
  input  logic       hdr_ready,
  input  hdr_info_t  hdr_info,
  output int         fail_count,
  output int         pending
);

  // Predicted parser state
  logic [2:0]            parse_phase;
  logic [7:0]            cur_tag;
  logic [31:0]           len_acc;
  logic [2:0]            len_left;
  logic [COUNT_BITS-1:0] octet_count;

  hdr_info_t hdr_expected_q[$];
  int        errors;

  // Build a result from the current tag
  function automatic hdr_info_t make_info(input logic [1:0] st, input logic [2:0] hdr,
                                          input logic [BODY_W-1:0] body,
                                          input logic partial, input logic indet);
    hdr_info_t r;
    r.status   = st;
    r.tag_byte = cur_tag;
    if (!cur_tag[7]) begin
      r.pkt_type = '0;
    end else if (cur_tag[6]) begin
      r.pkt_type = cur_tag[5:0];
    end else begin
      r.pkt_type = {2'b00, cur_tag[5:2]};
    end
    r.new_format    = cur_tag[7] & cur_tag[6];
    r.header_octets = hdr;
    r.body_length   = body;
    r.partial_start = partial;
    r.indeterminate = indet;
    return r;
  endfunction

  // Advance the predicted parser by one byte; return 1 when a header result is due
  function automatic bit decode_header_byte(input byte_item_t it, output hdr_info_t info);
    logic [7:0] b;
    logic       fin;
    logic [2:0] after_phase;
    bit         produced;
    b           = it.data_byte;
    fin         = it.last_byte;
    after_phase = fin ? PH_IDLE : PH_SKIP;
    produced    = 1'b0;
    info        = '0;
    case (parse_phase) inside
      PH_IDLE: begin
        cur_tag     = b;
        len_acc     = '0;
        len_left    = '0;
        octet_count = COUNT_BITS'(1);
        if (!b[7]) begin
          info        = make_info(ST_UNKNOWN, '0, '0, 1'b0, 1'b0);
          produced    = 1'b1;
          parse_phase = after_phase;
        end else if (b[6]) begin
          if (fin) begin
            info     = make_info(ST_BAD_NEW, '0, '0, 1'b0, 1'b0);
            produced = 1'b1;
          end else begin
            parse_phase = PH_NEW1;
          end
        end else if (b[1:0] == LT_INDET) begin
          if (fin) begin
            info     = make_info(ST_OK, HDR_TAG_ONLY, '0, 1'b0, 1'b1);
            produced = 1'b1;
          end else begin
            parse_phase = PH_COUNT;
          end
        end else if (fin) begin
          info     = make_info(ST_BAD_LEG, '0, '0, 1'b0, 1'b0);
          produced = 1'b1;
        end else begin
          case (b[1:0])
            LT_ONE:  len_left = 3'd1;
            LT_TWO:  len_left = 3'd2;
            default: len_left = 3'd4;
          endcase
          parse_phase = PH_LEG;
        end
      end
      PH_NEW1: begin
        if (b == NEW_FIVE_MARK) begin
          if (fin) begin
            info        = make_info(ST_BAD_NEW, '0, '0, 1'b0, 1'b0);
            produced    = 1'b1;
            parse_phase = PH_IDLE;
          end else begin
            len_acc     = '0;
            len_left    = 3'd4;
            parse_phase = PH_NEW5;
          end
        end else if (b >= NEW_PARTIAL_MIN) begin
          info        = make_info(ST_OK, HDR_ONE_LEN, 32'd1 << b[4:0], 1'b1, 1'b0);
          produced    = 1'b1;
          parse_phase = after_phase;
        end else if (b >= NEW_TWO_MIN) begin
          if (fin) begin
            info        = make_info(ST_BAD_NEW, '0, '0, 1'b0, 1'b0);
            produced    = 1'b1;
            parse_phase = PH_IDLE;
          end else begin
            len_acc     = {24'd0, b};
            parse_phase = PH_NEW2;
          end
        end else begin
          info        = make_info(ST_OK, HDR_ONE_LEN, {24'd0, b}, 1'b0, 1'b0);
          produced    = 1'b1;
          parse_phase = after_phase;
        end
      end
      PH_NEW2: begin
        info = make_info(ST_OK, HDR_TWO_LEN,
                         (({24'd0, len_acc[7:0]} - 32'd192) << 8) + {24'd0, b} + 32'd192,
                         1'b0, 1'b0);
        produced    = 1'b1;
        parse_phase = after_phase;
      end
      PH_NEW5, PH_LEG: begin
        len_acc  = {len_acc[23:0], b};
        len_left = len_left - 3'd1;
        if (len_left == 3'd0) begin
          if (parse_phase == PH_NEW5) begin
            info = make_info(ST_OK, HDR_FIVE_LEN, len_acc, 1'b0, 1'b0);
          end else begin
            case (cur_tag[1:0])
              LT_ONE:  info = make_info(ST_OK, HDR_ONE_LEN, len_acc, 1'b0, 1'b0);
              LT_TWO:  info = make_info(ST_OK, HDR_TWO_LEN, len_acc, 1'b0, 1'b0);
              default: info = make_info(ST_OK, HDR_FOUR_LEN, len_acc, 1'b0, 1'b0);
            endcase
          end
          produced    = 1'b1;
          parse_phase = after_phase;
        end else if (fin) begin
          info = make_info(parse_phase == PH_NEW5 ? ST_BAD_NEW : ST_BAD_LEG,
                           '0, '0, 1'b0, 1'b0);
          produced    = 1'b1;
          parse_phase = PH_IDLE;
        end
      end
      PH_COUNT: begin
        octet_count = octet_count + 1'b1;
        if (fin) begin
          info        = make_info(ST_OK, HDR_TAG_ONLY, BODY_W'(octet_count - 1'b1),
                                  1'b0, 1'b1);
          produced    = 1'b1;
          parse_phase = PH_IDLE;
        end
      end
      PH_SKIP: begin
        if (fin) begin
          parse_phase = PH_IDLE;
        end
      end
      default: begin
        parse_phase = PH_IDLE;
      end
    endcase
    return produced;
  endfunction

  // Compare one field and log a mismatch
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("t=%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Predict on each byte transfer, compare on each header transfer
  always @(posedge clk) begin : watch_channels
    hdr_info_t predicted;
    hdr_info_t want;
    bit        has_result;
    if (rst) begin
      parse_phase = PH_IDLE;
      cur_tag     = '0;
      len_acc     = '0;
      len_left    = '0;
      octet_count = '0;
      hdr_expected_q.delete();
    end else begin
      if (byte_valid && byte_ready) begin
        has_result = decode_header_byte(byte_item, predicted);
        if (has_result) begin
          hdr_expected_q.push_back(predicted);
        end
      end
      if (hdr_valid && hdr_ready) begin
        if (hdr_expected_q.size() == 0) begin
          errors++;
          $display("t=%0t: unexpected result, expected none, actual %p", $time, hdr_info);
        end else begin
          want = hdr_expected_q.pop_front();
          check_field("status", want.status, hdr_info.status);
          check_field("tag_byte", want.tag_byte, hdr_info.tag_byte);
          check_field("pkt_type", want.pkt_type, hdr_info.pkt_type);
          check_field("new_format", want.new_format, hdr_info.new_format);
          check_field("header_octets", want.header_octets, hdr_info.header_octets);
          check_field("body_length", want.body_length, hdr_info.body_length);
          check_field("partial_start", want.partial_start, hdr_info.partial_start);
          check_field("indeterminate", want.indeterminate, hdr_info.indeterminate);
        end
      end
    end
    pending    <= hdr_expected_q.size();
    fail_count <= errors;
  end

endmodule

### test/packet_header_parser_top_tb.sv
// ---------------------------------------------------------------------------
// packet_header_parser_top_tb
// Feeds the header parser with byte buffers: a short directed set covering
// every error and most header forms, then random well-formed, truncated and
// noise buffers with random idling on both channels and one long result
// stall. A checker beside the block predicts and compares the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_parser_top_tb;
  import phdr_pkg::*;

  localparam int BYTE_TARGET  = 900;
  localparam int CALM_FROM    = 700;
  localparam int HOLD_AT      = 120;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item  = '0;
  logic       hdr_valid;
  logic       hdr_ready  = 1'b0;
  hdr_info_t  hdr_info;

  int         fail_count;
  int         pending;
  int         bytes_sent  = 0;
  int         idle_cycles = 0;
  logic       idle_on     = 1'b1;
  logic       hold_req    = 1'b0;
  bit         hold_done   = 1'b0;
  logic [7:0] frame_q[$];

  always #2 clk = ~clk;

  packet_header_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_info  (hdr_info)
  );

  phdr_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_info  (hdr_info),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Offer one byte, with an optional gap first, and hold until it transfers
  task automatic offer_byte(input logic [7:0] d, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: d, last_byte: fin};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the whole frame, flagging its final byte
  task automatic offer_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      offer_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Build a random buffer: mostly valid headers, some truncated, some noise
  task automatic build_random_frame();
    int         pick;
    int         kind;
    int         n;
    logic [1:0] lt;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 7);
    if (pick < 6) begin
      n = $urandom_range(1, 5);
      repeat (n) frame_q.push_back(8'($urandom));
      return;
    end
    if (kind < 4) begin
      frame_q.push_back({2'b11, 6'($urandom)});
      case (kind)
        0: frame_q.push_back(8'($urandom_range(0, 191)));
        1: begin
          frame_q.push_back(8'($urandom_range(192, 223)));
          frame_q.push_back(8'($urandom));
        end
        2: frame_q.push_back(8'($urandom_range(224, 254)));
        default: begin
          frame_q.push_back(NEW_FIVE_MARK);
          repeat (4) frame_q.push_back(8'($urandom));
        end
      endcase
    end else begin
      case (kind)
        4:       lt = LT_ONE;
        5:       lt = LT_TWO;
        6:       lt = LT_FOUR;
        default: lt = LT_INDET;
      endcase
      frame_q.push_back({2'b10, 4'($urandom), lt});
      if (lt == LT_INDET) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
      end else if (lt == LT_ONE) begin
        n = 1;
      end else if (lt == LT_TWO) begin
        n = 2;
      end else begin
        n = 4;
      end
      repeat (n) frame_q.push_back(8'($urandom));
    end
    if (pick < 16 && frame_q.size() > 1) begin
      // cut the buffer short, inside the header unless the length is indeterminate
      n = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end else if (lt != LT_INDET || kind < 4) begin
      n = $urandom_range(0, 3);
      repeat (n) frame_q.push_back(8'($urandom));
    end
  endtask

  // Drive the result side: random stalls, one long hold-off
  initial begin : drive_hdr_ready
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hdr_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hdr_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hdr_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        hdr_ready <= 1'b1;
      end else begin
        hdr_ready <= 1'b1;
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (hdr_valid && hdr_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("packet_header_parser_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Reset, stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // unknown format, then a skipped trailing byte
    frame_q = '{8'h3C, 8'h55};
    offer_frame();
    // new-format tag alone
    frame_q = '{8'hC0};
    offer_frame();
    // one-octet length at its top, with a trailing byte
    frame_q = '{8'hC2, 8'hBF, 8'h11};
    offer_frame();
    // two-octet length at its bottom, highest packet type
    frame_q = '{8'hFF, 8'hC0, 8'h00};
    offer_frame();
    // partial lengths at both ends
    frame_q = '{8'hC1, 8'hE0};
    offer_frame();
    frame_q = '{8'hC1, 8'hFE};
    offer_frame();
    // five-octet length, all ones
    frame_q = '{8'hC1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    offer_frame();
    // legacy one-octet zero length
    frame_q = '{8'h80, 8'h00};
    offer_frame();
    // legacy indeterminate with two body bytes
    frame_q = '{8'hBF, 8'h01, 8'h02};
    offer_frame();
    // legacy two-octet length cut short
    frame_q = '{8'h89, 8'hAB};
    offer_frame();

    // random buffers
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= HOLD_AT && !hold_req) begin
        hold_req <= 1'b1;
      end
      if (bytes_sent >= CALM_FROM && idle_on) begin
        idle_on <= 1'b0;
      end
      build_random_frame();
      offer_frame();
    end
    byte_valid <= 1'b0;

    // wait for the last results, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("packet_header_parser_top_tb: PASS");
    end else begin
      $display("packet_header_parser_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/phdr_pkg.sv
rtl/phdr_in_stage.sv
rtl/phdr_parse.sv
rtl/phdr_out_reg.sv
rtl/packet_header_parser_top.sv
test/phdr_result_checker.sv
test/packet_header_parser_top_tb.sv
